FILE: rtl/swm_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the sliding window median filter
// no dependencies; used by the cell, the output queue and the top level

package swm_pkg;

	// width of the window size register and its reset value
	localparam int CFG_W = 7;
	localparam logic [CFG_W-1:0] CFG_RESET = 7'd3;

	// entries in the result queue ahead of the output port
	localparam int OUTQ_DEPTH = 4;

	// per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic accept;   // a sample beat is taken this cycle
		logic drain;    // drop the oldest cell without inserting
		logic clr;      // start of a new stream: every cell counts as empty
		logic drop_en;  // the cell whose age matches the drop age leaves
	} swm_ctl_t;

endpackage

FILE: rtl/swm_cell.sv
`timescale 1ns / 1ps
// one cell of the sorted chain: holds a sample, its age and a valid flag
// depends on swm_pkg for the broadcast command struct

module swm_cell #(
	parameter int SAMPLE_BITS = 32,
	parameter int AGE_W = 6,
	parameter int IDX = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  swm_pkg::swm_ctl_t      ctl,
	input  logic [SAMPLE_BITS-1:0] new_sample,
	input  logic [AGE_W-1:0]       drop_age,
	input  logic [AGE_W-1:0]       med_idx,
	input  logic                   left_valid,
	input  logic                   left_le,
	input  logic [SAMPLE_BITS-1:0] left_value,
	input  logic [AGE_W-1:0]       left_age,
	input  logic                   right_valid,
	input  logic                   right_le,
	input  logic [SAMPLE_BITS-1:0] right_value,
	input  logic [AGE_W-1:0]       right_age,
	input  logic                   del_in,
	output logic                   del_out,
	output logic                   valid,
	output logic                   le,
	output logic [SAMPLE_BITS-1:0] value,
	output logic [AGE_W-1:0]       age,
	output logic [SAMPLE_BITS-1:0] med_word
);

	logic                   valid_q;
	logic [SAMPLE_BITS-1:0] value_q;
	logic [AGE_W-1:0]       age_q;

	logic                   del_self;
	logic                   del_here;
	logic                   cur_valid, cur_le, prev_valid, prev_le;
	logic [SAMPLE_BITS-1:0] cur_value, prev_value;
	logic [AGE_W-1:0]       cur_age, prev_age;
	logic                   valid_d;
	logic [SAMPLE_BITS-1:0] value_d;
	logic [AGE_W-1:0]       age_d;

	// view of this cell as seen by its neighbors this cycle
	assign valid = valid_q && !ctl.clr;
	assign le = valid && ($signed(value_q) <= $signed(new_sample));
	assign value = value_q;
	assign age = age_q;

	// drop marker ripples toward higher cells
	assign del_self = valid && ctl.drop_en && (age_q == drop_age);
	assign del_here = del_in || del_self;
	assign del_out = del_here;

	// contents of this slot and the one below after the drop closes up
	always_comb begin
		if (del_here) begin
			cur_valid = right_valid;
			cur_le = right_le;
			cur_value = right_value;
			cur_age = right_age;
		end else begin
			cur_valid = valid;
			cur_le = le;
			cur_value = value_q;
			cur_age = age_q;
		end
		if (del_in) begin
			prev_valid = valid;
			prev_le = le;
			prev_value = value_q;
			prev_age = age_q;
		end else begin
			prev_valid = left_valid;
			prev_le = left_le;
			prev_value = left_value;
			prev_age = left_age;
		end
	end

	// insert: keep smaller-or-equal, take the new sample at the boundary, else shift up; drain closes up
	always_comb begin
		valid_d = valid_q;
		value_d = value_q;
		age_d = age_q;
		if (ctl.accept) begin
			if (cur_le) begin
				valid_d = cur_valid;
				value_d = cur_value;
				age_d = cur_age + AGE_W'(1);
			end else if (prev_le) begin
				valid_d = 1'b1;
				value_d = new_sample;
				age_d = '0;
			end else begin
				valid_d = prev_valid;
				value_d = prev_value;
				age_d = prev_age + AGE_W'(1);
			end
		end else if (ctl.drain) begin
			valid_d = cur_valid;
			value_d = cur_value;
			age_d = cur_age;
		end
	end

	// cell state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
		age_q <= age_d;
	end

	// contribution to the median read-out
	assign med_word = (med_idx == AGE_W'(IDX)) ? value_q : '0;

endmodule

FILE: rtl/swm_outq.sv
`timescale 1ns / 1ps
// small result queue between the median read-out and the output port
// depends on swm_pkg for its depth

module swm_outq #(
	parameter int DATA_W = 32
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         push,
	input  logic [DATA_W-1:0]                            push_data,
	output logic                                         out_valid,
	input  logic                                         out_ready,
	output logic [DATA_W-1:0]                            out_data,
	output logic [$clog2(swm_pkg::OUTQ_DEPTH + 1)-1:0]   count
);

	localparam int DEPTH = swm_pkg::OUTQ_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              pop;

	assign pop = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign out_data = entry_q[rd_ptr_q];
	assign count = count_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + CNT_W'(1);
				2'b01: count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/sliding_window_median.sv
`timescale 1ns / 1ps
// top level of the sliding window median filter: control, cell chain, result queue
// depends on swm_pkg, swm_cell and swm_outq

// Sliding window median filter. Samples are kept sorted in a chain of WINDOW_MAX
// cells; each accepted beat drops the oldest sample (when the window is full),
// inserts the new one in order and, once the window holds window_size samples,
// yields the lower median. One sample is accepted per clock cycle while in_ready
// is high; the median passes through the registered cell chain and is then read
// out of the median cell into a four-entry result queue. in_ready falls only
// while that queue, counting a result still on its way in, is full or, after
// window_size was lowered mid-stream, while the chain drops its surplus oldest
// samples at one per cycle. A window size of zero acts as one, sizes above
// WINDOW_MAX saturate. window_size may be written only while no sample is in
// flight.

module sliding_window_median #(
	parameter int WINDOW_MAX = 64,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         window_size_we,
	input  logic [swm_pkg::CFG_W-1:0]    window_size,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [SAMPLE_BITS-1:0]       sample,
	input  logic                         start_stream,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [SAMPLE_BITS-1:0]       median
);

	localparam int AGE_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CNT_W = $clog2(WINDOW_MAX + 1);
	localparam int CMP_W = (CNT_W > swm_pkg::CFG_W) ? CNT_W : swm_pkg::CFG_W;
	localparam int Q_CNT_W = $clog2(swm_pkg::OUTQ_DEPTH + 1);

	logic [swm_pkg::CFG_W-1:0] window_q;
	logic [CNT_W-1:0]          fill_q;
	logic                      pend_s1;

	logic [CMP_W-1:0]          win_ext;
	logic [CNT_W-1:0]          w_eff;
	logic [CNT_W-1:0]          fill_base;
	logic [CNT_W-1:0]          med_pos;
	logic                      need_drain;
	logic                      accept;
	logic                      full_before;
	logic                      makes_result;
	logic [AGE_W-1:0]          drop_age;
	swm_pkg::swm_ctl_t         ctl;

	logic [WINDOW_MAX-1:0]     c_valid, c_le, c_del;
	logic [SAMPLE_BITS-1:0]    c_value [WINDOW_MAX];
	logic [AGE_W-1:0]          c_age [WINDOW_MAX];
	logic [SAMPLE_BITS-1:0]    c_med [WINDOW_MAX];
	logic [SAMPLE_BITS-1:0]    med_word;

	logic [Q_CNT_W-1:0]        q_count;
	logic [Q_CNT_W:0]          q_occ;

	// window size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= swm_pkg::CFG_RESET;
		end else if (window_size_we) begin
			window_q <= window_size;
		end
	end

	// effective window: zero acts as one, saturate at the chain length
	always_comb begin
		win_ext = CMP_W'(window_q);
		if (win_ext == '0) begin
			w_eff = CNT_W'(1);
		end else if (win_ext > CMP_W'(WINDOW_MAX)) begin
			w_eff = CNT_W'(WINDOW_MAX);
		end else begin
			w_eff = win_ext[CNT_W-1:0];
		end
	end

	// handshake and per-cycle command
	assign q_occ = {1'b0, q_count} + (Q_CNT_W + 1)'(pend_s1);
	assign need_drain = (fill_q > w_eff);
	assign in_ready = !need_drain && (q_occ < (Q_CNT_W + 1)'(swm_pkg::OUTQ_DEPTH));
	assign accept = in_valid && in_ready;

	assign fill_base = start_stream ? '0 : fill_q;
	assign full_before = (fill_base == w_eff);
	assign makes_result = (fill_base >= w_eff - CNT_W'(1));

	always_comb begin
		ctl.accept = accept;
		ctl.drain = need_drain;
		ctl.clr = accept && start_stream;
		ctl.drop_en = need_drain || (accept && full_before);
		if (need_drain) begin
			drop_age = fill_q[AGE_W-1:0] - AGE_W'(1);
		end else begin
			drop_age = w_eff[AGE_W-1:0] - AGE_W'(1);
		end
	end

	// fill count and result pending flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= accept && makes_result;
			if (need_drain) begin
				fill_q <= fill_q - CNT_W'(1);
			end else if (accept) begin
				fill_q <= full_before ? w_eff : fill_base + CNT_W'(1);
			end
		end
	end

	// sorted cell chain
	assign med_pos = (w_eff - CNT_W'(1)) >> 1;

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		logic                   lv, ll, rv, rl, din;
		logic [SAMPLE_BITS-1:0] lval, rval;
		logic [AGE_W-1:0]       lage, rage;

		if (i == 0) begin : g_first
			assign lv = 1'b1;
			assign ll = 1'b1;
			assign lval = '0;
			assign lage = '0;
			assign din = 1'b0;
		end else begin : g_mid_l
			assign lv = c_valid[i-1];
			assign ll = c_le[i-1];
			assign lval = c_value[i-1];
			assign lage = c_age[i-1];
			assign din = c_del[i-1];
		end

		if (i == WINDOW_MAX - 1) begin : g_last
			assign rv = 1'b0;
			assign rl = 1'b0;
			assign rval = '0;
			assign rage = '0;
		end else begin : g_mid_r
			assign rv = c_valid[i+1];
			assign rl = c_le[i+1];
			assign rval = c_value[i+1];
			assign rage = c_age[i+1];
		end

		swm_cell #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.AGE_W(AGE_W),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.new_sample(sample),
			.drop_age(drop_age),
			.med_idx(med_pos[AGE_W-1:0]),
			.left_valid(lv),
			.left_le(ll),
			.left_value(lval),
			.left_age(lage),
			.right_valid(rv),
			.right_le(rl),
			.right_value(rval),
			.right_age(rage),
			.del_in(din),
			.del_out(c_del[i]),
			.valid(c_valid[i]),
			.le(c_le[i]),
			.value(c_value[i]),
			.age(c_age[i]),
			.med_word(c_med[i])
		);
	end

	// median read-out: only the selected cell drives nonzero
	always_comb begin
		med_word = '0;
		for (int i = 0; i < WINDOW_MAX; i++) begin
			med_word = med_word | c_med[i];
		end
	end

	// result queue
	swm_outq #(
		.DATA_W(SAMPLE_BITS)
	) u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(pend_s1),
		.push_data(med_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(median),
		.count(q_count)
	);

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(WINDOW_MAX))
		else $error("fill count above chain length");

	a_cells_match_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.clr |-> ($countones(c_valid) == int'(fill_q)))
		else $error("valid cells disagree with fill count");

	a_start_one: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && start_stream) |=> (fill_q == CNT_W'(1)))
		else $error("new stream did not leave exactly one sample");

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_occ <= (Q_CNT_W + 1)'(swm_pkg::OUTQ_DEPTH))
		else $error("results in flight exceed queue depth");

	a_full_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && makes_result) |=> (fill_q == $past(w_eff)))
		else $error("result produced without a full window");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the sliding window median filter
// depends on swm_pkg and sliding_window_median; holds its own window tracker

module tb;

	localparam int WMAX = 64;
	localparam int SB = 32;
	localparam int DRAIN_CYCLES = 10;
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASE_BEATS = 95;
	localparam logic signed [SB-1:0] S_MAX = 32'sh7fff_ffff;
	localparam logic signed [SB-1:0] S_MIN = 32'sh8000_0000;

	// tracks the sorted window and the medians still owed by the block
	class median_tracker;
		logic [swm_pkg::CFG_W-1:0] win_setting;
		logic signed [SB-1:0] vals [WMAX];
		int unsigned ages [WMAX];
		int unsigned fill;
		logic signed [SB-1:0] medians_due [$];
		int unsigned mismatches;
		int unsigned checked;
		int unsigned taken;

		function new();
			win_setting = swm_pkg::CFG_RESET;
			fill = 0;
			mismatches = 0;
			checked = 0;
			taken = 0;
		endfunction

		function void set_window(input logic [swm_pkg::CFG_W-1:0] w);
			win_setting = w;
		endfunction

		// an accepted sample beat: drop oldest, insert in order, maybe owe a median
		function void note_sample(input logic signed [SB-1:0] s, input logic fresh);
			int unsigned w, pos, i, oldest;
			w = win_setting;
			if (w < 1)
				w = 1;
			if (w > WMAX)
				w = WMAX;
			taken++;
			if (fresh)
				fill = 0;
			while (fill >= w) begin
				oldest = 0;
				for (i = 1; i < fill; i++)
					if (ages[i] > ages[oldest])
						oldest = i;
				for (i = oldest; i + 1 < fill; i++) begin
					vals[i] = vals[i+1];
					ages[i] = ages[i+1];
				end
				fill--;
			end
			for (i = 0; i < fill; i++)
				ages[i]++;
			// equal values go after the ones already stored
			pos = 0;
			while (pos < fill && vals[pos] <= s)
				pos++;
			for (i = fill; i > pos; i--) begin
				vals[i] = vals[i-1];
				ages[i] = ages[i-1];
			end
			vals[pos] = s;
			ages[pos] = 0;
			fill++;
			if (fill == w)
				medians_due = {medians_due, vals[(w-1)/2]};
		endfunction

		// an accepted result beat against the oldest owed median
		function void check_median(input logic signed [SB-1:0] got);
			logic signed [SB-1:0] want;
			checked++;
			if (medians_due.size() == 0) begin
				$error("median: no result expected, actual %0d", got);
				mismatches++;
			end else begin
				want = medians_due.pop_front();
				if (got !== want) begin
					$error("median: expected %0d, actual %0d", want, got);
					mismatches++;
				end
			end
		endfunction

		function int unsigned pending();
			return medians_due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic window_size_we;
	logic [swm_pkg::CFG_W-1:0] window_size;
	logic in_valid;
	logic in_ready;
	logic signed [SB-1:0] sample;
	logic start_stream;
	logic out_valid;
	logic out_ready;
	logic signed [SB-1:0] median;

	median_tracker sb = new();
	bit no_idle;
	int unsigned cycles;
	int unsigned settings_used;

	sliding_window_median #(
		.WINDOW_MAX(WMAX),
		.SAMPLE_BITS(SB)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.window_size_we(window_size_we),
		.window_size(window_size),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.start_stream(start_stream),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.median(median)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// cycle count and watchdog
	always @(posedge clk)
		cycles <= cycles + 1;

	initial begin
		while (cycles < CYCLE_LIMIT)
			@(posedge clk);
		$display("timeout after %0d cycles, %0d medians still owed", cycles, sb.pending());
		$display("sliding_window_median regression: fail");
		$finish;
	end

	// result side: random back-pressure, one long hold-off, check each beat
	initial begin
		int stall;
		int r;
		bit held;
		out_ready = 1'b0;
		stall = 0;
		held = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_median(median);
			if (!held && sb.checked >= 200) begin
				held = 1;
				stall = 300;
			end
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if (no_idle) begin
				out_ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 75) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					if (r < 92)
						stall = $urandom_range(0, 2);
					else if (r < 99)
						stall = $urandom_range(3, 9);
					else
						stall = $urandom_range(20, 50);
				end
			end
		end
	end

	// sender gap length: mostly none, a few long
	function automatic int gap_len();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// sample mix: full range, clustered small values for ties, extremes
	function automatic logic signed [SB-1:0] pick_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return $urandom;
		if (r < 70)
			return $signed($urandom_range(0, 8)) - 4;
		if (r < 80) begin
			case ($urandom_range(0, 3))
				0: return S_MAX;
				1: return S_MIN;
				2: return '0;
				default: return '1;
			endcase
		end
		return $signed($urandom_range(0, 2000)) - 1000;
	endfunction

	// one sample beat, after an optional gap; returns at the accepting edge
	task automatic push_sample(input logic signed [SB-1:0] s, input logic fresh);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		start_stream <= fresh;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_sample(s, fresh);
	endtask

	// stop sending, wait until every owed median is back and the chain is quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(input logic [swm_pkg::CFG_W-1:0] w);
		window_size_we <= 1'b1;
		window_size <= w;
		@(posedge clk);
		window_size_we <= 1'b0;
		sb.set_window(w);
		settings_used++;
	endtask

	// stimulus
	initial begin
		int unsigned phase_win [14];
		int p, k;
		logic [swm_pkg::CFG_W-1:0] w;

		arst_n = 1'b0;
		window_size_we = 1'b0;
		window_size = '0;
		in_valid = 1'b0;
		sample = '0;
		start_stream = 1'b0;
		no_idle = 1'b0;
		settings_used = 1;
		phase_win = '{64, 2, 10, 127, 1, 0, 33, 4, 100, 7, 64, 3, 0, 0};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window of three: extremes, ties, clear mid-stream
		push_sample(S_MAX, 1'b0);
		push_sample(S_MIN, 1'b0);
		push_sample('0, 1'b0);
		push_sample('1, 1'b0);
		push_sample(S_MAX, 1'b0);
		push_sample(S_MAX, 1'b0);
		push_sample(S_MIN, 1'b1);
		push_sample(32'sd5, 1'b0);
		push_sample(32'sd5, 1'b0);
		push_sample(32'sd5, 1'b0);

		// even window: lower median
		settle();
		write_window(7'd2);
		push_sample(32'sd1, 1'b0);
		push_sample(32'sd2, 1'b0);

		// window of one, then zero acting as one
		settle();
		write_window(7'd1);
		push_sample(S_MAX, 1'b0);
		push_sample(S_MIN, 1'b0);
		settle();
		write_window('0);
		push_sample('1, 1'b0);
		push_sample(32'sd7, 1'b0);

		// shrink mid-stream from five to two, then grow to four
		settle();
		write_window(7'd5);
		for (k = 1; k <= 5; k++)
			push_sample(k, 1'b0);
		settle();
		write_window(7'd2);
		push_sample(-32'sd3, 1'b0);
		push_sample(32'sd9, 1'b0);
		settle();
		write_window(7'd4);
		push_sample(32'sd4, 1'b0);
		push_sample(-32'sd8, 1'b0);
		push_sample(32'sd6, 1'b0);

		// random phases; the stream is mostly kept across window changes
		phase_win[12] = $urandom_range(0, 127);
		phase_win[13] = $urandom_range(1, WMAX);
		for (p = 0; p < 14; p++) begin
			settle();
			no_idle = (p % 3 == 2);
			w = phase_win[p][swm_pkg::CFG_W-1:0];
			write_window(w);
			for (k = 0; k < PHASE_BEATS; k++)
				push_sample(pick_sample(),
					(k == 0 && $urandom_range(0, 2) == 0) || $urandom_range(0, 149) == 0);
		end

		settle();
		no_idle = 1'b0;
		$display("%0d samples sent, %0d medians checked across %0d window settings",
			sb.taken, sb.checked, settings_used);
		$display("window sizes 0 to 127, shrink and grow mid-stream, one long output hold-off");
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("sliding_window_median regression: pass");
		else
			$display("sliding_window_median regression: fail");
		$finish;
	end

endmodule
